// File: sv/mtp_pkg.sv
// ----------------------------------------------------------------------------
// mtp_pkg: shared definitions for the MT19937 generator
// Holds the table geometry, the generator constants, the memory request
// bundle and the twist and temper functions.
// ----------------------------------------------------------------------------
package mtp_pkg;

  localparam int unsigned TableWords = 624;
  localparam int unsigned AddrW      = 10;

  localparam logic [AddrW-1:0] LAST_IDX      = AddrW'(TableWords - 1);
  localparam logic [AddrW-1:0] SHIFT_M       = AddrW'(397);
  localparam logic [AddrW-1:0] SPLIT_AT      = AddrW'(227);
  localparam logic [AddrW-1:0] POS_EXHAUSTED = AddrW'(TableWords);
  localparam logic [AddrW-1:0] POS_UNSEEDED  = AddrW'(625);

  localparam logic [31:0] DEFAULT_SEED = 32'd5489;
  localparam logic [31:0] INIT_MULT    = 32'h6c07_8965;
  localparam logic [31:0] TWIST_XOR    = 32'h9908_B0DF;
  localparam logic [31:0] UPPER_BIT    = 32'h8000_0000;
  localparam logic [31:0] LOWER_BITS   = 32'h7fff_ffff;
  localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;

  localparam int unsigned INIT_SHIFT = 30;
  localparam int unsigned TEMPER_L   = 18;

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [31:0]      word_t;

  // One write port and two read ports on the state table.
  typedef struct packed {
    logic  we;
    addr_t waddr;
    word_t wdata;
    addr_t raddr_a;
    addr_t raddr_b;
  } mem_req_t;

  function automatic word_t twist_word(word_t cur, word_t nxt, word_t far);
    word_t y;
    y = (cur & UPPER_BIT) | (nxt & LOWER_BITS);
    return far ^ (y >> 1) ^ (y[0] ? TWIST_XOR : 32'd0);
  endfunction

  function automatic word_t temper(word_t x);
    word_t y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> TEMPER_L);
    return y;
  endfunction

endpackage

// File: sv/mersenne_twister_prng_unit.sv
// ----------------------------------------------------------------------------
// mersenne_twister_prng_unit: 32-bit MT19937 random word generator
// Command-driven generator with the 624-word state in a synchronous table.
// A reseed command fills the table; a draw command returns one tempered word.
// ----------------------------------------------------------------------------
//
//  Channel  Ports                          Handshake
//  -------  -----------------------------  ------------------------------------
//  input    in_action, in_seed_value       taken when start is high, busy low
//  result   out_random_word                one-cycle strobe on out_valid
//
// A draw with words left in the table reaches the result strobe through the
// draw read state, the registered table read and the output register.
// A reseed writes word 0 in the accept cycle, then walks the other 623 words,
// each in a multiply state, then an add-and-write state, and gives no result.
// When the table is used up, a draw first regenerates it in place, each word
// in a read state, then a twist-and-write state.
// The first draw after reset seeds with 5489 and regenerates before returning.
// Reset is synchronous and active low; the receiver cannot stall results.
// ----------------------------------------------------------------------------
module mersenne_twister_prng_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_action,
  input  logic [31:0]         in_seed_value,
  output logic                out_valid,
  output mtp_pkg::word_t      out_random_word
);
  import mtp_pkg::*;

  // One-hot sequencer states.
  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_SEED_MUL = 7'b0000010,
    ST_SEED_WR  = 7'b0000100,
    ST_REGEN_RD = 7'b0001000,
    ST_REGEN_WR = 7'b0010000,
    ST_DRAW_RD  = 7'b0100000,
    ST_DRAW_OUT = 7'b1000000
  } state_t;

  state_t   state_r, state_nxt;
  addr_t    pos_r, pos_nxt;          // read position, 625 marks unseeded
  addr_t    cnt_r, cnt_nxt;          // word index during seeding and twist
  logic     draw_pend_r, draw_pend_nxt;
  word_t    prev_r, prev_nxt;        // previous word during seeding
  word_t    prod_r, prod_nxt;        // registered seeding product
  word_t    cur_r, cur_nxt;          // word k of the twist, old value
  word_t    word0_r, word0_nxt;      // copy of table word 0
  logic     out_valid_r, out_valid_nxt;
  word_t    out_word_r, out_word_nxt;

  mem_req_t req;
  word_t    rdata_a;
  word_t    rdata_b;
  word_t    seed_word;
  word_t    twist_res;
  logic     accept;

  mtp_table u_table (
    .clk     (clk),
    .req     (req),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  assign accept    = start && (state_r == ST_IDLE);
  assign seed_word = prod_r + {{(32 - AddrW){1'b0}}, cnt_r};
  // Entry k+1 is old during the twist but for the wrap to word 0, which is new;
  // the far entry is old below the split point and new from it on, as in-order writes give.
  assign twist_res = twist_word(cur_r, rdata_a, rdata_b);

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    draw_pend_nxt = draw_pend_r;
    prev_nxt      = prev_r;
    prod_nxt      = prod_r;
    cur_nxt       = cur_r;
    word0_nxt     = word0_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    req           = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (!in_action) begin
            // Reseed: word 0 is the seed itself.
            req.we        = 1'b1;
            req.waddr     = '0;
            req.wdata     = in_seed_value;
            prev_nxt      = in_seed_value;
            word0_nxt     = in_seed_value;
            cnt_nxt       = addr_t'(1);
            draw_pend_nxt = 1'b0;
            state_nxt     = ST_SEED_MUL;
          end else if (pos_r == POS_UNSEEDED) begin
            // First draw after reset seeds with the default, then twists.
            req.we        = 1'b1;
            req.waddr     = '0;
            req.wdata     = DEFAULT_SEED;
            prev_nxt      = DEFAULT_SEED;
            word0_nxt     = DEFAULT_SEED;
            cnt_nxt       = addr_t'(1);
            draw_pend_nxt = 1'b1;
            state_nxt     = ST_SEED_MUL;
          end else if (pos_r >= POS_EXHAUSTED) begin
            cnt_nxt   = '0;
            cur_nxt   = word0_r;
            state_nxt = ST_REGEN_RD;
          end else begin
            state_nxt = ST_DRAW_RD;
          end
        end
      end

      ST_SEED_MUL: begin
        prod_nxt  = INIT_MULT * (prev_r ^ (prev_r >> INIT_SHIFT));
        state_nxt = ST_SEED_WR;
      end

      ST_SEED_WR: begin
        req.we    = 1'b1;
        req.waddr = cnt_r;
        req.wdata = seed_word;
        prev_nxt  = seed_word;
        if (cnt_r == LAST_IDX) begin
          pos_nxt = POS_EXHAUSTED;
          if (draw_pend_r) begin
            cnt_nxt   = '0;
            cur_nxt   = word0_r;
            state_nxt = ST_REGEN_RD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          cnt_nxt   = cnt_r + addr_t'(1);
          state_nxt = ST_SEED_MUL;
        end
      end

      ST_REGEN_RD: begin
        req.raddr_a = (cnt_r == LAST_IDX) ? addr_t'(0) : cnt_r + addr_t'(1);
        req.raddr_b = (cnt_r < SPLIT_AT) ? cnt_r + SHIFT_M : cnt_r - SPLIT_AT;
        state_nxt   = ST_REGEN_WR;
      end

      ST_REGEN_WR: begin
        req.we    = 1'b1;
        req.waddr = cnt_r;
        req.wdata = twist_res;
        cur_nxt   = rdata_a;
        if (cnt_r == '0) begin
          word0_nxt = twist_res;
        end
        if (cnt_r == LAST_IDX) begin
          pos_nxt   = '0;
          state_nxt = ST_DRAW_RD;
        end else begin
          cnt_nxt   = cnt_r + addr_t'(1);
          state_nxt = ST_REGEN_RD;
        end
      end

      ST_DRAW_RD: begin
        req.raddr_a = pos_r;
        state_nxt   = ST_DRAW_OUT;
      end

      ST_DRAW_OUT: begin
        out_word_nxt  = temper(rdata_a);
        out_valid_nxt = 1'b1;
        pos_nxt       = pos_r + addr_t'(1);
        state_nxt     = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= POS_UNSEEDED;
      cnt_r       <= '0;
      draw_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      cnt_r       <= cnt_nxt;
      draw_pend_r <= draw_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk) begin
    prev_r     <= prev_nxt;
    prod_r     <= prod_nxt;
    cur_r      <= cur_nxt;
    word0_r    <= word0_nxt;
    out_word_r <= out_word_nxt;
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_random_word = out_word_r;

  // A draw from a filled table strobes its word via the draw read and output states.
  a_fast_draw: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_action && (pos_r < POS_EXHAUSTED)) |=> ##2 out_valid)
    else $error("draw from filled table did not return a word in time");

  // Results are single-cycle strobes, one per draw.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // The read position never enters the unreachable range.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_UNSEEDED)
    else $error("read position out of range");

  // Table writes stay inside the 624 words.
  a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
    req.we |-> (req.waddr <= LAST_IDX))
    else $error("table write beyond last word");

endmodule

// File: sv/mtp_table.sv
// ----------------------------------------------------------------------------
// mtp_table: 624-word state table of the generator
// Synchronous memory with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module mtp_table (
  input  logic               clk,
  input  mtp_pkg::mem_req_t  req,
  output mtp_pkg::word_t     rdata_a,
  output mtp_pkg::word_t     rdata_b
);
  import mtp_pkg::*;

  word_t mem [TableWords];
  word_t rdata_a_r;
  word_t rdata_b_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_a_r <= mem[req.raddr_a];
    rdata_b_r <= mem[req.raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for mersenne_twister_prng_unit
// Drives reseed and draw words through the start/busy command port and keeps
// its own MT19937 state to predict every tempered word. Each strobed output
// word is checked against the oldest predicted word.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef mtp_pkg::word_t word_t;

  // Command codes carried on in_action.
  localparam bit ACT_RESEED = 1'b0;
  localparam bit ACT_DRAW   = 1'b1;

  // Generator geometry and constants, kept locally for the predictor.
  localparam int unsigned MT_LEN       = 624;
  localparam int unsigned MT_OFFSET    = 397;
  localparam logic [9:0]  POS_SPENT    = 10'd624;
  localparam logic [9:0]  POS_NO_SEED  = 10'd625;
  localparam word_t       BOOT_SEED    = 32'd5489;
  localparam word_t       SEED_MULT    = 32'h6c07_8965;
  localparam word_t       TWIST_MAG    = 32'h9908_B0DF;
  localparam word_t       TMASK_B      = 32'h9d2c_5680;
  localparam word_t       TMASK_C      = 32'hefc6_0000;

  // Stimulus sizing. The long run of draws must pass the end of the table
  // so that the block regenerates from a state it reached by itself.
  localparam int unsigned MIXED_ITEMS  = 40;
  localparam int unsigned QUIET_TAIL   = 120;
  localparam int unsigned SETTLE_CYC   = 40;
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;

  // --------------------------------------------------------------------------
  // Scoreboard: a private copy of the generator state plus the queue of words
  // the block still owes us.
  // --------------------------------------------------------------------------
  class mt_word_scoreboard;
    word_t       mt_state [MT_LEN];
    logic [9:0]  rd_pos;
    word_t       owed_words [$];
    int unsigned error_cnt;

    function new();
      rd_pos    = POS_NO_SEED;
      error_cnt = 0;
    endfunction

    function void fill_table(word_t seed);
      word_t prev;
      mt_state[0] = seed;
      for (int i = 1; i < MT_LEN; i++) begin
        prev        = mt_state[i-1];
        mt_state[i] = SEED_MULT * (prev ^ (prev >> 30)) + word_t'(i);
      end
      rd_pos = POS_SPENT;
    endfunction

    // In-place twist; modular indexing picks up already-updated words exactly
    // where the sequential algorithm does.
    function void twist_table();
      word_t mix;
      word_t nxt;
      word_t far_w;
      for (int k = 0; k < MT_LEN; k++) begin
        nxt   = mt_state[(k + 1) % MT_LEN];
        far_w = mt_state[(k + MT_OFFSET) % MT_LEN];
        mix   = {mt_state[k][31], nxt[30:0]};
        mt_state[k] = far_w ^ {1'b0, mix[31:1]} ^ (mix[0] ? TWIST_MAG : '0);
      end
      rd_pos = '0;
    endfunction

    function word_t tempered(word_t raw);
      word_t t;
      t = raw ^ {11'b0, raw[31:11]};
      t = t ^ ({t[24:0], 7'b0} & TMASK_B);
      t = t ^ ({t[16:0], 15'b0} & TMASK_C);
      t = t ^ {18'b0, t[31:18]};
      return t;
    endfunction

    // Called for every accepted command word.
    function void note_command(bit act, word_t seed);
      if (act == ACT_RESEED) begin
        fill_table(seed);
      end else begin
        if (rd_pos >= POS_SPENT) begin
          if (rd_pos == POS_NO_SEED) begin
            fill_table(BOOT_SEED);
          end
          twist_table();
        end
        owed_words.push_back(tempered(mt_state[rd_pos]));
        rd_pos = rd_pos + 10'd1;
      end
    endfunction

    // Called for every strobed output word.
    function void check_word(word_t got);
      word_t want;
      if (owed_words.size() == 0) begin
        $display("%0t: unexpected output word, expected none, actual %h", $time, got);
        error_cnt++;
      end else begin
        want = owed_words.pop_front();
        if (got !== want) begin
          $display("%0t: random_word mismatch, expected %h, actual %h", $time, want, got);
          error_cnt++;
        end
      end
    endfunction

    function int unsigned owed_count();
      return owed_words.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_action;
  logic [31:0] in_seed_value;
  logic        out_valid;
  word_t       out_random_word;

  mt_word_scoreboard sb;
  int unsigned       accepted_cnt;
  int unsigned       cycle_cnt;
  int unsigned       item_cnt;
  bit                idle_on;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  mersenne_twister_prng_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_seed_value   (in_seed_value),
    .out_valid       (out_valid),
    .out_random_word (out_random_word)
  );

  // --------------------------------------------------------------------------
  // Monitor. Everything is sampled at the rising edge; inputs only change on
  // the falling edge, so there is no ordering hazard. The output word is
  // checked before the new command is noted, although either order works
  // since a result always trails its own command by at least one edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        sb.check_word(out_random_word);
      end
      if (start === 1'b1 && busy === 1'b0) begin
        sb.note_command(in_action, in_seed_value);
        accepted_cnt++;
      end
    end
  end

  // Watchdog: a hung handshake or a result that never shows ends the run.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("mersenne_twister_prng_unit test failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks. All of them are entered and left at a falling edge.
  // --------------------------------------------------------------------------

  // Presents one command word and holds it until the monitor sees it taken.
  // start is left high so that a following word streams without a gap.
  task automatic send_word(bit act, word_t seed);
    int unsigned prior_cnt;
    prior_cnt      = accepted_cnt;
    start         <= 1'b1;
    in_action     <= act;
    in_seed_value <= seed;
    do @(negedge clk); while (accepted_cnt == prior_cnt);
  endtask

  // Drops start for a few cycles with junk on the payload ports.
  task automatic idle_burst(int unsigned cycles);
    start         <= 1'b0;
    in_action     <= 1'($urandom);
    in_seed_value <= $urandom;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic issue(bit act, word_t seed);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      idle_burst($urandom_range(1, 7));
    end
    send_word(act, seed);
    item_cnt++;
  endtask

  // Seeds lean toward the corner values now and then.
  function automatic word_t pick_seed();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return BOOT_SEED;
      default: return $urandom;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned run_len;
    int unsigned pick;
    sb            = new();
    accepted_cnt  = 0;
    cycle_cnt     = 0;
    item_cnt      = 0;
    idle_on       = 1'b1;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_action     = ACT_RESEED;
    in_seed_value = '0;

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. The very first draw finds the block unseeded, so it must
    // seed itself with the default and regenerate before answering.
    issue(ACT_DRAW,   $urandom);
    issue(ACT_DRAW,   $urandom);
    issue(ACT_DRAW,   $urandom);
    // A reseed gives no word; the draw after it regenerates without seeding.
    issue(ACT_RESEED, 32'h0000_0000);
    issue(ACT_DRAW,   32'hFFFF_FFFF);
    issue(ACT_DRAW,   32'h0000_0000);
    issue(ACT_RESEED, 32'hFFFF_FFFF);
    issue(ACT_DRAW,   $urandom);
    issue(ACT_RESEED, BOOT_SEED);
    issue(ACT_DRAW,   $urandom);
    issue(ACT_DRAW,   $urandom);
    // Back-to-back reseeds: only the last one may count.
    issue(ACT_RESEED, 32'h0000_0001);
    issue(ACT_RESEED, 32'h8000_0000);
    issue(ACT_DRAW,   $urandom);
    issue(ACT_RESEED, 32'hAAAA_AAAA);
    issue(ACT_DRAW,   32'h5555_5555);
    issue(ACT_RESEED, 32'h5555_5555);
    issue(ACT_DRAW,   32'hAAAA_AAAA);
    issue(ACT_DRAW,   $urandom);

    // Mixed random part: mostly a reseed followed by a burst of draws, some
    // bare draw bursts, and some runs of reseeds with nothing drawn.
    while (item_cnt < MIXED_ITEMS) begin
      idle_on = ($urandom_range(0, 4) != 0);
      pick    = $urandom_range(0, 99);
      if (pick < 70) begin
        issue(ACT_RESEED, pick_seed());
        run_len = $urandom_range(1, 40);
        repeat (run_len) issue(ACT_DRAW, $urandom);
      end else if (pick < 85) begin
        run_len = $urandom_range(1, 30);
        repeat (run_len) issue(ACT_DRAW, $urandom);
      end else begin
        run_len = $urandom_range(1, 3);
        repeat (run_len) issue(ACT_RESEED, pick_seed());
      end
    end

    // Hold the sender off until every owed word has come back.
    start <= 1'b0;
    while (sb.owed_count() != 0) @(negedge clk);

    // Long draw run from a fresh seed. It walks past the end of the table,
    // so the block regenerates from state it advanced on its own. The last
    // stretch runs with no idling at all.
    idle_on = 1'b1;
    issue(ACT_RESEED, $urandom);
    run_len = $urandom_range(626, 640);
    for (int j = 0; j < run_len; j++) begin
      idle_on = (j < run_len - QUIET_TAIL);
      issue(ACT_DRAW, $urandom);
    end

    // Drain: wait for the last owed word and for the block to go idle, then
    // a few more cycles to catch any stray strobe.
    start <= 1'b0;
    while (sb.owed_count() != 0 || busy !== 1'b0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);

    if (sb.error_cnt == 0 && sb.owed_count() == 0) begin
      $display("mersenne_twister_prng_unit test passed");
    end else begin
      $display("mersenne_twister_prng_unit test failed");
    end
    $finish;
  end

endmodule
